// ===== rtl/oid_pkg.sv =====
`timescale 1ns / 1ps

package oid_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned DataW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    OP_APPEND   = 2'd0,
    OP_INSERT   = 2'd1,
    OP_POP_HEAD = 2'd2,
    OP_POP_TAIL = 2'd3
  } oid_op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } oid_status_e;

  // Broadcast from the controller to every cell in the chain
  typedef struct packed {
    logic                    en;
    oid_op_e                 op;
    logic signed [DataW-1:0] value;
  } oid_cell_ctrl_t;

endpackage

// ===== rtl/oid_if.sv =====
`timescale 1ns / 1ps

interface oid_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           func;
  logic signed [oid_pkg::DataW-1:0]     value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface oid_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [oid_pkg::DataW-1:0]     value_res;
  logic [1:0]                           status;
  logic [oid_pkg::CountW-1:0]           count;

  modport source (output valid, output value_res, output status, output count, input ready);
  modport sink   (input valid, input value_res, input status, input count, output ready);
endinterface

// ===== rtl/ordered_insert_deque_top.sv =====
`timescale 1ns / 1ps
// A result is registered and presented in the cycle after its request transfer.
// Throughput: one request per cycle unless the held response is stalled; every
// cell compares and shifts in parallel, the insert position ripples once along
// the cell chain in that cycle. Reset: asynchronous active-low reset empties
// the store and clears the output valid; entry contents are not reset.

module ordered_insert_deque_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  oid_req_if.sink     req_i,
  oid_rsp_if.source   rsp_o
);

  logic [oid_pkg::CntW-1:0]          occ_q, occ_d;
  logic                              rsp_valid_q;
  logic signed [oid_pkg::DataW-1:0]  res_q, res_d;
  oid_pkg::oid_status_e              status_q, status_d;

  logic                              accept;
  logic                              full, empty;
  oid_pkg::oid_op_e                  op;
  oid_pkg::oid_cell_ctrl_t           ctrl;

  logic signed [oid_pkg::DataW-1:0]  cell_data [oid_pkg::Depth];
  logic signed [oid_pkg::DataW-1:0]  left_in   [oid_pkg::Depth];
  logic signed [oid_pkg::DataW-1:0]  right_in  [oid_pkg::Depth];
  logic [oid_pkg::Depth:0]           found;
  logic [oid_pkg::IdxW-1:0]          tail_idx;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign op          = oid_pkg::oid_op_e'(req_i.func);
  assign full        = (occ_q == oid_pkg::CntW'(oid_pkg::Depth));
  assign empty       = (occ_q == '0);
  assign tail_idx    = oid_pkg::IdxW'(occ_q - oid_pkg::CntW'(1));

  always_comb begin
    occ_d    = occ_q;
    res_d    = '0;
    status_d = oid_pkg::ST_DONE;
    ctrl.op    = op;
    ctrl.value = req_i.value;
    ctrl.en    = 1'b0;
    case (op)
      oid_pkg::OP_APPEND, oid_pkg::OP_INSERT: begin
        if (full) begin
          status_d = oid_pkg::ST_FULL;
        end else begin
          ctrl.en = accept;
          occ_d   = occ_q + oid_pkg::CntW'(1);
        end
      end
      oid_pkg::OP_POP_HEAD: begin
        if (empty) begin
          status_d = oid_pkg::ST_EMPTY;
        end else begin
          ctrl.en = accept;
          res_d   = cell_data[0];
          occ_d   = occ_q - oid_pkg::CntW'(1);
        end
      end
      default: begin
        if (empty) begin
          status_d = oid_pkg::ST_EMPTY;
        end else begin
          res_d = cell_data[tail_idx];
          occ_d = occ_q - oid_pkg::CntW'(1);
        end
      end
    endcase
  end

  // Neighbor links; the chain ends take don't-care data
  always_comb begin
    for (int i = 0; i < oid_pkg::Depth; i++) begin
      left_in[i]  = (i == 0) ? req_i.value : cell_data[(i == 0) ? 0 : i - 1];
      right_in[i] = (i == oid_pkg::Depth - 1) ? req_i.value :
                    cell_data[(i == oid_pkg::Depth - 1) ? i : i + 1];
    end
  end

  assign found[0] = 1'b0;

  for (genvar g = 0; g < oid_pkg::Depth; g++) begin : g_cell
    oid_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .valid_i (oid_pkg::CntW'(g) < occ_q),
      .left_i  (left_in[g]),
      .right_i (right_in[g]),
      .found_i (found[g]),
      .found_o (found[g+1]),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q       <= occ_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q    <= res_d;
      status_q <= status_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.value_res = res_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.count     = oid_pkg::CountW'(occ_q);

  // Occupancy never goes past the store size
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= oid_pkg::CntW'(oid_pkg::Depth))
    else $error("occupancy above depth");

  // A pop on an empty store reports empty with a zero value
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && empty && (op == oid_pkg::OP_POP_HEAD || op == oid_pkg::OP_POP_TAIL))
    |=> (rsp_o.status == oid_pkg::ST_EMPTY) && (rsp_o.value_res == '0) && (occ_q == '0))
    else $error("pop on empty store misreported");

  // An insert that is not refused grows the store by one
  a_insert_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !full && (op == oid_pkg::OP_APPEND || op == oid_pkg::OP_INSERT))
    |=> occ_q == $past(occ_q) + oid_pkg::CntW'(1))
    else $error("insert did not grow occupancy");

  // A refused insert leaves the count unchanged
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (op == oid_pkg::OP_APPEND || op == oid_pkg::OP_INSERT))
    |=> (occ_q == $past(occ_q)) && (rsp_o.status == oid_pkg::ST_FULL))
    else $error("full store changed on insert");

endmodule

// ===== rtl/oid_cell.sv =====
`timescale 1ns / 1ps

module oid_cell (
  input  logic                                clk_i,
  input  oid_pkg::oid_cell_ctrl_t             ctrl_i,
  input  logic                                valid_i,
  input  logic signed [oid_pkg::DataW-1:0]    left_i,
  input  logic signed [oid_pkg::DataW-1:0]    right_i,
  input  logic                                found_i,
  output logic                                found_o,
  output logic signed [oid_pkg::DataW-1:0]    data_o
);

  logic signed [oid_pkg::DataW-1:0] data_q, data_d;
  logic                             pass;

  // pass: the new value belongs somewhere after this entry
  assign pass    = valid_i &&
                   ((ctrl_i.op == oid_pkg::OP_APPEND) || (ctrl_i.value < data_q));
  assign found_o = found_i | ~pass;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      oid_pkg::OP_APPEND, oid_pkg::OP_INSERT: begin
        if (found_i) begin
          data_d = left_i;
        end else if (!pass) begin
          data_d = ctrl_i.value;
        end
      end
      oid_pkg::OP_POP_HEAD: begin
        data_d = right_i;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      data_q <= data_d;
    end
  end

endmodule
